/* sv/palette_error_diffusion_dither_core_assert.svh */
`ifndef PALETTE_ERROR_DIFFUSION_DITHER_CORE_ASSERT_SVH
`define PALETTE_ERROR_DIFFUSION_DITHER_CORE_ASSERT_SVH

// checked only out of reset
`define PEDD_ASSERT(lbl, prop) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) \
        else $error("%m: assertion failed");

// checked through reset as well
`define PEDD_ASSERT_ALWAYS(lbl, prop) \
    lbl: assert property (@(posedge i_clk) prop) else $error("%m: assertion failed");

`endif

/* sv/pedd_pkg.sv */
`default_nettype none
package pedd_pkg;

    localparam int PALETTE_DEPTH = 64;
    localparam int LINE_MAX      = 1024;
    localparam int PAL_AW        = $clog2(PALETTE_DEPTH);
    localparam int LB_AW         = $clog2(LINE_MAX);
    localparam int CNT_W         = $clog2(PALETTE_DEPTH + 1);
    localparam int LEN_W         = $clog2(LINE_MAX + 1);
    localparam int DIST_W        = 23;

    localparam logic [4:0] W_BLUE  = 5'd11;
    localparam logic [5:0] W_GREEN = 6'd59;
    localparam logic [4:0] W_RED   = 5'd30;

    localparam logic       OP_PAL = 1'b0;
    localparam logic       OP_PIX = 1'b1;
    localparam logic [7:0] TRANSP_INDEX = 8'hFF;

    localparam logic [2:0] CFG_PAL_COUNT = 3'd0;
    localparam logic [2:0] CFG_LINE_LEN  = 3'd1;
    localparam logic [2:0] CFG_LINE_CNT  = 3'd2;
    localparam logic [2:0] CFG_ALPHA_THR = 3'd3;
    localparam logic [2:0] CFG_ALPHA_EN  = 3'd4;

    typedef enum logic [3:0] {
        S_CLEAR, S_IDLE, S_START, S_LBRD, S_VAL, S_SRCH, S_DRAIN,
        S_FETCH, S_ERR, S_WL, S_WH, S_DONE
    } t_state;

    typedef struct packed {
        logic [CNT_W-1:0] pal_count;
        logic [LEN_W-1:0] line_len;
        logic [15:0]      line_cnt;
        logic [7:0]       alpha_thr;
        logic             alpha_en;
    } t_cfg;

    typedef struct packed {
        logic ready;
        logic clr;
        logic norm;
        logic lb_rd;
        logic calc_val;
        logic issue;
        logic fetch;
        logic calc_err;
        logic wr_left;
        logic wr_here;
        logic out_load;
    } t_cmd;

    typedef struct packed {
        logic in_valid;
        logic in_pix;
        logic clr_last;
        logic transp;
        logic issue_last;
        logic pipe_empty;
        logic out_free;
    } t_sts;

endpackage
`default_nettype wire

/* sv/palette_error_diffusion_dither_core.sv */
// channel  | direction | contents
// s_axis   | in        | tuser opcode, tdata entry/blue/green/red/alpha
// m_axis   | out       | tuser transparent, tdata index/blue/green/red
// cfg      | in        | register index and write data, always ready
//
// an opaque pixel passes the start, line read, value, search, drain, fetch, error, left write,
// here write and done states, the search reading one palette entry per cycle
// a transparent pixel skips the search, drain and fetch states
// a palette write is taken in the idle state, and the block stays ready for the next request
// after reset every entry of the line error memory is cleared, with no request taken
// a finished result waits in the output register while the next request is taken
// a stalled output holds the block only when the next result is ready
`default_nettype none
module palette_error_diffusion_dither_core
    import pedd_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_s_tvalid,
    output logic             o_s_tready,
    input  wire logic [39:0] i_s_tdata,   // entry_number, blue, green, red, alpha
    input  wire logic        i_s_tuser,   // opcode
    output logic             o_m_tvalid,
    input  wire logic        i_m_tready,
    output logic      [31:0] o_m_tdata,   // palette_index, out_blue, out_green, out_red
    output logic             o_m_tuser,   // transparent
    input  wire logic        i_cfg_valid,
    output logic             o_cfg_ready,
    input  wire logic [2:0]  i_cfg_index,
    input  wire logic [15:0] i_cfg_data
);
    logic [7:0]  r_pal_count;
    logic [10:0] r_line_len;
    logic [15:0] r_line_cnt;
    logic [7:0]  r_alpha_thr;
    logic        r_alpha_en;
    t_cfg        cfg;
    t_cmd        cmd;
    t_sts        sts;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pal_count <= 8'd1;
            r_line_len  <= 11'd1024;
            r_line_cnt  <= 16'd1;
            r_alpha_thr <= 8'd127;
            r_alpha_en  <= 1'b0;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                CFG_PAL_COUNT: r_pal_count <= i_cfg_data[7:0];
                CFG_LINE_LEN:  r_line_len  <= i_cfg_data[10:0];
                CFG_LINE_CNT:  r_line_cnt  <= i_cfg_data;
                CFG_ALPHA_THR: r_alpha_thr <= i_cfg_data[7:0];
                CFG_ALPHA_EN:  r_alpha_en  <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    // out-of-range settings are clamped here
    always_comb begin
        if (r_pal_count == 8'd0) begin
            cfg.pal_count = CNT_W'(1);
        end else if (32'(r_pal_count) > PALETTE_DEPTH) begin
            cfg.pal_count = CNT_W'(PALETTE_DEPTH);
        end else begin
            cfg.pal_count = CNT_W'(r_pal_count);
        end
        if (r_line_len == 11'd0) begin
            cfg.line_len = LEN_W'(1);
        end else if (32'(r_line_len) > LINE_MAX) begin
            cfg.line_len = LEN_W'(LINE_MAX);
        end else begin
            cfg.line_len = LEN_W'(r_line_len);
        end
        cfg.line_cnt  = (r_line_cnt == 16'd0) ? 16'd1 : r_line_cnt;
        cfg.alpha_thr = r_alpha_thr;
        cfg.alpha_en  = r_alpha_en;
    end

    assign o_s_tready = cmd.ready;

    pedd_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_sts   (sts),
        .o_cmd   (cmd)
    );

    pedd_datapath u_dp (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cmd      (cmd),
        .i_cfg      (cfg),
        .o_sts      (sts),
        .i_s_tvalid (i_s_tvalid),
        .i_s_tdata  (i_s_tdata),
        .i_s_tuser  (i_s_tuser),
        .i_m_tready (i_m_tready),
        .o_m_tvalid (o_m_tvalid),
        .o_m_tdata  (o_m_tdata),
        .o_m_tuser  (o_m_tuser)
    );
endmodule
`default_nettype wire

/* sv/pedd_ram.sv */
`default_nettype none
module pedd_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  wire logic [WIDTH-1:0]         i_wr_data,
    input  wire logic                     i_rd_en,
    input  wire logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic      [WIDTH-1:0]         o_rd_data
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            o_rd_data <= r_mem[i_rd_addr];
        end
    end
endmodule
`default_nettype wire

/* sv/pedd_ctrl.sv */
`default_nettype none
module pedd_ctrl
    import pedd_pkg::*;
(
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire t_sts i_sts,
    output t_cmd      o_cmd
);
    t_state r_state, n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        unique case (r_state)
            S_CLEAR: begin
                o_cmd.clr = 1'b1;
                if (i_sts.clr_last) n_state = S_IDLE;
            end
            S_IDLE: begin
                o_cmd.ready = 1'b1;
                if (i_sts.in_valid && i_sts.in_pix) n_state = S_START;
            end
            S_START: begin
                o_cmd.norm = 1'b1;
                n_state = S_LBRD;
            end
            S_LBRD: begin
                o_cmd.lb_rd = 1'b1;
                n_state = S_VAL;
            end
            S_VAL: begin
                o_cmd.calc_val = 1'b1;
                n_state = i_sts.transp ? S_ERR : S_SRCH;
            end
            S_SRCH: begin
                o_cmd.issue = 1'b1;
                if (i_sts.issue_last) n_state = S_DRAIN;
            end
            S_DRAIN: begin
                if (i_sts.pipe_empty) n_state = S_FETCH;
            end
            S_FETCH: begin
                o_cmd.fetch = 1'b1;
                n_state = S_ERR;
            end
            S_ERR: begin
                o_cmd.calc_err = 1'b1;
                n_state = S_WL;
            end
            S_WL: begin
                o_cmd.wr_left = 1'b1;
                n_state = S_WH;
            end
            S_WH: begin
                o_cmd.wr_here = 1'b1;
                n_state = S_DONE;
            end
            S_DONE: begin
                if (i_sts.out_free) begin
                    o_cmd.out_load = 1'b1;
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_CLEAR;
        endcase
    end
endmodule
`default_nettype wire

/* sv/pedd_datapath.sv */
`default_nettype none
module pedd_datapath
    import pedd_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire t_cmd        i_cmd,
    input  wire t_cfg        i_cfg,
    output t_sts             o_sts,
    input  wire logic        i_s_tvalid,
    input  wire logic [39:0] i_s_tdata,
    input  wire logic        i_s_tuser,
    input  wire logic        i_m_tready,
    output logic             o_m_tvalid,
    output logic      [31:0] o_m_tdata,
    output logic             o_m_tuser
);
    // pixel and position state
    logic [7:0]              r_pix [3];
    logic                    r_transp;
    logic [LB_AW-1:0]        r_col;
    logic [15:0]             r_line;
    logic signed [7:0]       r_carry [3];
    logic signed [4:0]       r_pend [3];
    logic signed [9:0]       r_held [3];
    logic [7:0]              r_val [3];
    logic signed [8:0]       r_err [3];
    logic [7:0]              r_chosen [3];
    logic [7:0]              r_idx_out;
    logic [LB_AW-1:0]        r_clr_addr;

    // search pipeline
    logic [CNT_W-1:0]        r_idx;
    logic                    r_v0, r_v1, r_v2;
    logic [PAL_AW-1:0]       r_i0, r_i1, r_i2;
    logic [15:0]             r_sq [3];
    logic [DIST_W-1:0]       r_dist;
    logic [DIST_W-1:0]       r_best_dist;
    logic [PAL_AW-1:0]       r_best;

    logic                    accept;
    logic                    pal_we;
    logic [PAL_AW-1:0]       pal_rd_addr;
    logic [23:0]             pal_q;
    logic                    lb_we;
    logic [LB_AW-1:0]        lb_wr_addr;
    logic [29:0]             lb_wr_data;
    logic [29:0]             lb_q;
    logic                    last_line;
    logic                    has_right;
    logic                    col_wrap;
    logic [LEN_W:0]          col_inc;
    logic [16:0]             line_inc;
    logic signed [11:0]      ex [3];
    logic signed [11:0]      s1 [3], s3 [3], s5 [3], s7 [3];
    logic signed [9:0]       here_val [3];
    logic signed [9:0]       left_val [3];

    assign accept = i_cmd.ready && i_s_tvalid;
    assign pal_we = accept && (i_s_tuser == OP_PAL)
                    && (32'(i_s_tdata[7:0]) < PALETTE_DEPTH);

    always_comb begin
        pal_rd_addr = r_idx[PAL_AW-1:0];
        if (i_cmd.fetch) pal_rd_addr = r_best;
    end

    pedd_ram #(.WIDTH(24), .DEPTH(PALETTE_DEPTH)) u_pal_ram (
        .i_clk     (i_clk),
        .i_wr_en   (pal_we),
        .i_wr_addr (i_s_tdata[PAL_AW-1:0]),
        .i_wr_data (i_s_tdata[31:8]),
        .i_rd_en   (i_cmd.issue || i_cmd.fetch),
        .i_rd_addr (pal_rd_addr),
        .o_rd_data (pal_q)
    );

    assign last_line = (17'(r_line) + 17'd1) >= 17'(i_cfg.line_cnt);
    assign col_inc   = (LEN_W + 1)'(r_col) + 1'b1;
    assign has_right = col_inc < (LEN_W + 1)'(i_cfg.line_len);

    // error shares, arithmetic shift rounds toward minus infinity
    always_comb begin
        for (int c = 0; c < 3; c++) begin
            ex[c] = 12'(r_err[c]);
            s1[c] = ex[c] >>> 4;
            s3[c] = ((ex[c] <<< 1) + ex[c]) >>> 4;
            s5[c] = ((ex[c] <<< 2) + ex[c]) >>> 4;
            s7[c] = ((ex[c] <<< 3) - ex[c]) >>> 4;
            here_val[c] = last_line ? 10'sd0 : (10'(r_pend[c]) + s5[c][9:0]);
            left_val[c] = r_held[c] + s3[c][9:0];
        end
    end

    always_comb begin
        lb_we      = 1'b0;
        lb_wr_addr = r_col;
        lb_wr_data = {here_val[2], here_val[1], here_val[0]};
        if (i_cmd.clr) begin
            lb_we      = 1'b1;
            lb_wr_addr = r_clr_addr;
            lb_wr_data = '0;
        end else if (i_cmd.wr_left) begin
            lb_we      = (r_col != '0) && !last_line;
            lb_wr_addr = r_col - 1'b1;
            lb_wr_data = {left_val[2], left_val[1], left_val[0]};
        end else if (i_cmd.wr_here) begin
            lb_we      = 1'b1;
        end
    end

    pedd_ram #(.WIDTH(30), .DEPTH(LINE_MAX)) u_line_ram (
        .i_clk     (i_clk),
        .i_wr_en   (lb_we),
        .i_wr_addr (lb_wr_addr),
        .i_wr_data (lb_wr_data),
        .i_rd_en   (i_cmd.lb_rd),
        .i_rd_addr (r_col),
        .o_rd_data (lb_q)
    );

    assign col_wrap = 32'(r_col) >= 32'(i_cfg.line_len);
    assign line_inc = 17'(r_line) + 17'd1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr_addr <= '0;
            r_col      <= '0;
            r_line     <= '0;
            r_idx      <= '0;
            r_v0       <= 1'b0;
            r_v1       <= 1'b0;
            r_v2       <= 1'b0;
            o_m_tvalid <= 1'b0;
            for (int c = 0; c < 3; c++) begin
                r_carry[c] <= '0;
                r_pend[c]  <= '0;
                r_held[c]  <= '0;
            end
        end else begin
            if (i_cmd.clr) r_clr_addr <= r_clr_addr + 1'b1;

            if (accept && i_s_tuser == OP_PIX) begin
                r_pix[0] <= i_s_tdata[15:8];
                r_pix[1] <= i_s_tdata[23:16];
                r_pix[2] <= i_s_tdata[31:24];
                r_transp <= i_cfg.alpha_en && (i_s_tdata[39:32] < i_cfg.alpha_thr);
            end

            // a shortened geometry starts a new line or frame here
            if (i_cmd.norm) begin
                if (col_wrap) begin
                    r_col <= '0;
                    for (int c = 0; c < 3; c++) begin
                        r_carry[c] <= '0;
                        r_pend[c]  <= '0;
                    end
                    if (r_line >= i_cfg.line_cnt) begin
                        r_line <= (17'd1 >= 17'(i_cfg.line_cnt)) ? 16'd0 : 16'd1;
                    end else begin
                        r_line <= (line_inc >= 17'(i_cfg.line_cnt)) ? 16'd0 : line_inc[15:0];
                    end
                end else if (r_line >= i_cfg.line_cnt) begin
                    r_line <= '0;
                end
            end

            if (i_cmd.calc_val) begin
                r_idx       <= '0;
                r_best      <= '0;
                r_best_dist <= '1;
            end

            if (i_cmd.issue) r_idx <= r_idx + 1'b1;
            r_v0 <= i_cmd.issue;
            r_i0 <= r_idx[PAL_AW-1:0];
            r_v1 <= r_v0;
            r_i1 <= r_i0;
            r_v2 <= r_v1;
            r_i2 <= r_i1;
            if (r_v2 && (r_dist < r_best_dist)) begin
                r_best_dist <= r_dist;
                r_best      <= r_i2;
            end

            if (i_cmd.wr_left) begin
                // nothing beyond the write itself
            end

            if (i_cmd.wr_here) begin
                for (int c = 0; c < 3; c++) begin
                    r_held[c]  <= here_val[c];
                    r_carry[c] <= has_right ? s7[c][7:0] : 8'sd0;
                    r_pend[c]  <= (has_right && !last_line) ? s1[c][4:0] : 5'sd0;
                end
                if (!has_right) begin
                    r_col <= '0;
                    for (int c = 0; c < 3; c++) begin
                        r_carry[c] <= '0;
                        r_pend[c]  <= '0;
                    end
                    r_line <= (line_inc >= 17'(i_cfg.line_cnt)) ? 16'd0 : line_inc[15:0];
                end else begin
                    r_col <= col_inc[LB_AW-1:0];
                end
            end

            if (i_cmd.out_load) begin
                o_m_tvalid <= 1'b1;
            end else if (i_m_tready) begin
                o_m_tvalid <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (i_cmd.calc_val) begin
            for (int c = 0; c < 3; c++) begin
                logic signed [11:0] sum;
                sum = 12'({4'd0, r_pix[c]}) + 12'(r_carry[c])
                      + 12'($signed(lb_q[c*10 +: 10]));
                if (sum < 12'sd0) begin
                    r_val[c] <= 8'd0;
                end else if (sum > 12'sd255) begin
                    r_val[c] <= 8'd255;
                end else begin
                    r_val[c] <= sum[7:0];
                end
            end
        end

        if (r_v0) begin
            for (int c = 0; c < 3; c++) begin
                logic signed [8:0] d;
                d = $signed({1'b0, r_val[c]}) - $signed({1'b0, pal_q[c*8 +: 8]});
                r_sq[c] <= 16'(18'(d) * 18'(d));
            end
        end

        if (r_v1) begin
            r_dist <= DIST_W'(r_sq[0]) * DIST_W'(W_BLUE)
                      + DIST_W'(r_sq[1]) * DIST_W'(W_GREEN)
                      + DIST_W'(r_sq[2]) * DIST_W'(W_RED);
        end

        if (i_cmd.calc_err) begin
            for (int c = 0; c < 3; c++) begin
                if (r_transp) begin
                    r_chosen[c] <= r_pix[c];
                    r_err[c]    <= '0;
                end else begin
                    r_chosen[c] <= pal_q[c*8 +: 8];
                    r_err[c]    <= $signed({1'b0, r_val[c]}) - $signed({1'b0, pal_q[c*8 +: 8]});
                end
            end
            r_idx_out <= r_transp ? TRANSP_INDEX : 8'(r_best);
        end

        if (i_cmd.out_load) begin
            o_m_tdata <= {r_chosen[2], r_chosen[1], r_chosen[0], r_idx_out};
            o_m_tuser <= r_transp;
        end
    end

    always_comb begin
        o_sts.in_valid   = i_s_tvalid;
        o_sts.in_pix     = (i_s_tuser == OP_PIX);
        o_sts.clr_last   = (32'(r_clr_addr) == LINE_MAX - 1);
        o_sts.transp     = r_transp;
        o_sts.issue_last = (r_idx + 1'b1) >= i_cfg.pal_count;
        o_sts.pipe_empty = !(r_v0 || r_v1 || r_v2);
        o_sts.out_free   = !o_m_tvalid || i_m_tready;
    end
endmodule
`default_nettype wire

/* sv/pedd_checker.sv */
`default_nettype none
`include "palette_error_diffusion_dither_core_assert.svh"
module pedd_checker (
    input wire logic        i_clk,
    input wire logic        i_rst_n,
    input wire logic        i_s_tvalid,
    input wire logic        o_s_tready,
    input wire logic        i_s_tuser,
    input wire logic        o_m_tvalid,
    input wire logic        i_m_tready,
    input wire logic [31:0] o_m_tdata,
    input wire logic        o_m_tuser
);
    `PEDD_ASSERT(a_out_hold, o_m_tvalid && !i_m_tready |=> o_m_tvalid)
    `PEDD_ASSERT(a_out_stable, o_m_tvalid && !i_m_tready |=> $stable(o_m_tdata))
    `PEDD_ASSERT(a_transp_index, o_m_tvalid && o_m_tuser |-> o_m_tdata[7:0] == 8'hFF)
    `PEDD_ASSERT(a_pixel_busy, i_s_tvalid && o_s_tready && i_s_tuser |=> !o_s_tready)
    `PEDD_ASSERT_ALWAYS(a_reset_clears, !i_rst_n |=> !o_s_tready && !o_m_tvalid)
endmodule

bind palette_error_diffusion_dither_core pedd_checker u_pedd_checker (.*);
`default_nettype wire
